### hw/rtl/eltd_pkg.sv
// Shared types, constants and calendar tables for the epoch to local time block.
// Used by eltd_front, eltd_queue, eltd_back and epoch_to_local_time_us_dst.
package eltd_pkg;

    localparam int TBL_N       = 139;                // calendar years 1970..2108
    localparam int SECS_DAY    = 86400;
    localparam int SECS_HOUR   = 3600;
    localparam int Q_DEPTH     = 4;
    localparam int OBUF_DEPTH  = 2;

    // floor(x / 675) for x < 2**25: (x * DAY_RECIP) >> 36
    localparam logic [26:0] DAY_RECIP  = 27'd101806633;
    // year estimate, within one of the true year: (days * YEAR_RECIP) >> 20
    localparam logic [11:0] YEAR_RECIP = 12'd2871;
    // floor(s / 3600) for s < 86400: (s * HOUR_RECIP) >> 27
    localparam logic [15:0] HOUR_RECIP = 16'd37283;
    // floor(r / 60) for r < 3600: (r * MIN_RECIP) >> 18
    localparam logic [12:0] MIN_RECIP  = 13'd4370;

    typedef logic [TBL_N-1:0][16:0] t_day_tbl;
    typedef logic [TBL_N-1:0][33:0] t_sec_tbl;

    typedef struct packed {
        logic [16:0]        sod;
        logic signed [4:0]  std_off;
        logic               follows;
        logic               active;
    } t_mid;

    typedef struct packed {
        logic               dst_active;
        logic signed [4:0]  applied_offset;
        logic [4:0]         local_hours;
        logic [5:0]         local_minutes;
        logic [5:0]         local_seconds;
        logic [3:0]         hour_twelve;
        logic               is_pm;
    } t_res;

    function automatic bit f_leap(input int yr);
        return (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
    endfunction

    function automatic int f_sunday_from(input int day);
        int wd;
        wd = (day + 4) % 7;
        return (wd == 0) ? day : day + 7 - wd;
    endfunction

    function automatic int f_year_day(input int idx);
        int d;
        d = 0;
        for (int i = 0; i < idx; i++) begin
            d = d + (f_leap(1970 + i) ? 366 : 365);
        end
        return d;
    endfunction

    function automatic t_day_tbl f_year_start_tbl();
        t_day_tbl t;
        for (int i = 0; i < TBL_N; i++) begin
            t[i] = 17'(f_year_day(i));
        end
        return t;
    endfunction

    // second Sunday of March, in seconds since the epoch
    function automatic t_sec_tbl f_dst_on_tbl();
        t_sec_tbl t;
        longint   s;
        for (int i = 0; i < TBL_N; i++) begin
            s = longint'(f_sunday_from(f_year_day(i) + 59 + int'(f_leap(1970 + i))) + 7);
            t[i] = 34'(s * SECS_DAY);
        end
        return t;
    endfunction

    // first Sunday of November, in seconds since the epoch
    function automatic t_sec_tbl f_dst_off_tbl();
        t_sec_tbl t;
        longint   s;
        for (int i = 0; i < TBL_N; i++) begin
            s = longint'(f_sunday_from(f_year_day(i) + 304 + int'(f_leap(1970 + i))));
            t[i] = 34'(s * SECS_DAY);
        end
        return t;
    endfunction

    localparam t_day_tbl YEAR_START = f_year_start_tbl();
    localparam t_sec_tbl DST_ON     = f_dst_on_tbl();
    localparam t_sec_tbl DST_OFF    = f_dst_off_tbl();

endpackage

### hw/rtl/eltd_front.sv
// Front pipeline: splits the epoch into day and second of day, finds the year
// and classifies the epoch against the DST window. Depends on eltd_pkg.
module eltd_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    output logic                o_full,
    input  logic [31:0]         i_epoch,
    input  logic signed [4:0]   i_std_off,
    input  logic                i_follows,
    input  logic [4:0]          i_on_hour,
    input  logic [4:0]          i_off_hour,
    input  logic                i_q_full,
    output logic                o_q_push,
    output eltd_pkg::t_mid      o_q_data
);
    logic [5:0]         r_v;
    logic               w_en;

    logic [31:0]        r_a_epoch, r_b_epoch, r_c_epoch, r_d_epoch, r_e_epoch;
    logic [4:0]         r_a_off, r_b_off, r_c_off, r_d_off, r_e_off, r_f_off;
    logic               r_a_fol, r_b_fol, r_c_fol, r_d_fol, r_e_fol, r_f_fol;
    logic [15:0]        r_b_q, r_c_days;
    logic [7:0]         r_c_est, r_d_yi;
    logic [16:0]        r_c_sod, r_d_sod, r_e_sod, r_f_sod;
    logic [33:0]        r_e_on, r_e_end;
    logic               r_f_act;

    logic [51:0]        w_qprod;
    logic [31:0]        w_qsec;
    logic [27:0]        w_eprod;
    logic [7:0]         n_yi;

    assign w_en     = !(r_v[5] && i_q_full);
    assign o_full   = !w_en;
    assign o_q_push = r_v[5] && !i_q_full;

    assign w_qprod = 52'(r_a_epoch[31:7]) * 52'(eltd_pkg::DAY_RECIP);
    assign w_qsec  = 32'(r_b_q) * 32'(eltd_pkg::SECS_DAY);
    assign w_eprod = 28'(r_b_q) * 28'(eltd_pkg::YEAR_RECIP);

    // correct the year estimate by one either way
    always_comb begin
        if (17'(r_c_days) < eltd_pkg::YEAR_START[r_c_est]) begin
            n_yi = r_c_est - 8'd1;
        end else if (17'(r_c_days) >= eltd_pkg::YEAR_START[r_c_est + 8'd1]) begin
            n_yi = r_c_est + 8'd1;
        end else begin
            n_yi = r_c_est;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_en) begin
            r_v <= {r_v[4:0], i_push};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_epoch <= i_epoch;
            r_a_off   <= i_std_off;
            r_a_fol   <= i_follows;

            r_b_epoch <= r_a_epoch;
            r_b_off   <= r_a_off;
            r_b_fol   <= r_a_fol;
            r_b_q     <= w_qprod[51:36];

            r_c_epoch <= r_b_epoch;
            r_c_off   <= r_b_off;
            r_c_fol   <= r_b_fol;
            r_c_days  <= r_b_q;
            r_c_sod   <= 17'(r_b_epoch - w_qsec);
            r_c_est   <= w_eprod[27:20];

            r_d_epoch <= r_c_epoch;
            r_d_off   <= r_c_off;
            r_d_fol   <= r_c_fol;
            r_d_sod   <= r_c_sod;
            r_d_yi    <= n_yi;

            r_e_epoch <= r_d_epoch;
            r_e_off   <= r_d_off;
            r_e_fol   <= r_d_fol;
            r_e_sod   <= r_d_sod;
            r_e_on    <= eltd_pkg::DST_ON[r_d_yi]
                         + 34'(i_on_hour) * 34'(eltd_pkg::SECS_HOUR);
            r_e_end   <= eltd_pkg::DST_OFF[r_d_yi]
                         + 34'(i_off_hour) * 34'(eltd_pkg::SECS_HOUR);

            r_f_off   <= r_e_off;
            r_f_fol   <= r_e_fol;
            r_f_sod   <= r_e_sod;
            r_f_act   <= (34'(r_e_epoch) >= r_e_on) && (34'(r_e_epoch) < r_e_end);
        end
    end

    assign o_q_data.sod     = r_f_sod;
    assign o_q_data.std_off = $signed(r_f_off);
    assign o_q_data.follows = r_f_fol;
    assign o_q_data.active  = r_f_act;

endmodule

### hw/rtl/eltd_queue.sv
// Short queue between the front and back pipelines.
// Depends on eltd_pkg for the item type and depth.
module eltd_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  eltd_pkg::t_mid  i_data,
    output logic            o_full,
    input  logic            i_pop,
    output eltd_pkg::t_mid  o_data,
    output logic            o_empty
);
    eltd_pkg::t_mid r_mem [eltd_pkg::Q_DEPTH];
    logic [1:0]     r_wr, r_rd;
    logic [2:0]     r_cnt;
    logic           w_wr, w_rd;

    assign o_full  = (r_cnt == 3'(eltd_pkg::Q_DEPTH));
    assign o_empty = (r_cnt == 3'd0);
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) r_wr <= r_wr + 2'd1;
            if (w_rd) r_rd <= r_rd + 2'd1;
            r_cnt <= r_cnt + 3'(w_wr) - 3'(w_rd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr] <= i_data;
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 3'(eltd_pkg::Q_DEPTH))
        else $error("queue count overflow");
    a_cnt_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_wr && !w_rd) |=> (r_cnt == $past(r_cnt) + 3'd1))
        else $error("queue count missed a write");
    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != 3'(eltd_pkg::Q_DEPTH)) |-> (r_wr - r_rd == r_cnt[1:0]))
        else $error("queue pointers disagree with count");

endmodule

### hw/rtl/eltd_back.sv
// Back pipeline: applies the offset, wraps the second of day, splits it into
// hours, minutes and seconds, and holds results in a two-entry output buffer.
// Depends on eltd_pkg.
module eltd_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  eltd_pkg::t_mid  i_q_data,
    input  logic            i_q_empty,
    output logic            o_q_pop,
    input  logic            i_pop,
    output logic            o_empty,
    output eltd_pkg::t_res  o_res
);
    logic [4:0]             r_v;
    logic                   w_en;

    logic                   r_p_act, r_q_act, r_r_act, r_s_act, r_t_act;
    logic [4:0]             r_p_app, r_q_app, r_r_app, r_s_app, r_t_app;
    logic signed [18:0]     r_p_s;
    logic [16:0]            r_q_s, r_r_s;
    logic [4:0]             r_r_hh, r_s_hh, r_t_hh;
    logic [11:0]            r_s_rem, r_t_rem;
    logic [5:0]             r_t_mm;

    logic signed [5:0]      w_sum, w_app;
    logic signed [18:0]     n_s1;
    logic [16:0]            n_wrap;
    logic [32:0]            w_hprod;
    logic [24:0]            w_mprod;
    logic [11:0]            w_mins;
    logic [4:0]             w_h12;
    eltd_pkg::t_res         w_res;

    eltd_pkg::t_res         r_buf [eltd_pkg::OBUF_DEPTH];
    logic                   r_wr, r_rd;
    logic [1:0]             r_cnt;
    logic                   w_push, w_take;

    assign w_en    = !(r_v[4] && r_cnt == 2'(eltd_pkg::OBUF_DEPTH));
    assign o_q_pop = w_en && !i_q_empty;

    // saturate the applied offset at +15
    assign w_sum = 6'(i_q_data.std_off) + $signed({5'd0, i_q_data.follows && i_q_data.active});
    assign w_app = (w_sum > 6'sd15) ? 6'sd15 : w_sum;
    assign n_s1  = $signed({2'b00, i_q_data.sod}) + 19'(w_app) * 19'sd3600;

    always_comb begin
        if (r_p_s < 19'sd0) begin
            n_wrap = 17'(r_p_s + 19'sd86400);
        end else if (r_p_s >= 19'sd86400) begin
            n_wrap = 17'(r_p_s - 19'sd86400);
        end else begin
            n_wrap = 17'(r_p_s);
        end
    end

    assign w_hprod = 33'(r_q_s) * 33'(eltd_pkg::HOUR_RECIP);
    assign w_mprod = 25'(r_s_rem) * 25'(eltd_pkg::MIN_RECIP);
    assign w_mins  = 12'(r_t_mm) * 12'd60;
    assign w_h12   = (r_t_hh >= 5'd12) ? r_t_hh - 5'd12 : r_t_hh;

    assign w_res.dst_active     = r_t_act;
    assign w_res.applied_offset = $signed(r_t_app);
    assign w_res.local_hours    = r_t_hh;
    assign w_res.local_minutes  = r_t_mm;
    assign w_res.local_seconds  = 6'(r_t_rem - w_mins);
    assign w_res.hour_twelve    = (w_h12 == 5'd0) ? 4'd12 : w_h12[3:0];
    assign w_res.is_pm          = (r_t_hh >= 5'd12);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_en) begin
            r_v <= {r_v[3:0], o_q_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p_act <= i_q_data.active;
            r_p_app <= 5'(w_app);
            r_p_s   <= n_s1;

            r_q_act <= r_p_act;
            r_q_app <= r_p_app;
            r_q_s   <= n_wrap;

            r_r_act <= r_q_act;
            r_r_app <= r_q_app;
            r_r_s   <= r_q_s;
            r_r_hh  <= w_hprod[31:27];

            r_s_act <= r_r_act;
            r_s_app <= r_r_app;
            r_s_hh  <= r_r_hh;
            r_s_rem <= 12'(r_r_s - 17'(r_r_hh) * 17'(eltd_pkg::SECS_HOUR));

            r_t_act <= r_s_act;
            r_t_app <= r_s_app;
            r_t_hh  <= r_s_hh;
            r_t_rem <= r_s_rem;
            r_t_mm  <= w_mprod[23:18];
        end
    end

    // output buffer
    assign w_push  = r_v[4] && w_en;
    assign w_take  = i_pop && !o_empty;
    assign o_empty = (r_cnt == 2'd0);
    assign o_res   = r_buf[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wr <= !r_wr;
            if (w_take) r_rd <= !r_rd;
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_take);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_buf[r_wr] <= w_res;
        end
    end

    a_obuf_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'(eltd_pkg::OBUF_DEPTH))
        else $error("output buffer overflow");
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> (r_v == $past(r_v)))
        else $error("back pipeline moved while stalled");

endmodule

### hw/rtl/epoch_to_local_time_us_dst.sv
// Top level of the epoch to local time converter with the US DST rule.
// Holds the configuration registers; instantiates eltd_front, eltd_queue, eltd_back.
//
// Usage:
//   Input side is a queue write port: an item transfers on a clock edge with
//   push high and full low. Result side is a queue read port: the oldest
//   result sits on the o_ result ports while empty is low and transfers on a
//   clock edge with pop high.
//   Configuration: i_cfg_we writes i_cfg_data into register i_cfg_index
//   (0 = DST start UTC hour, 1 = DST end UTC hour) at once. Write only while
//   no item is in flight.
//   From input transfer to result visible, an item passes six front stages
//   (the first loads at the transfer edge), the middle queue, five back
//   stages and the output buffer.
//   Throughput is one item per cycle, set by the fully pipelined front and
//   back parts. When the receiver stalls, the output buffer fills, the back
//   stalls, the four-entry queue fills, and then full rises.
//   Reset (synchronous, active low) empties all stages and queues and sets
//   the start hour to 8 and the end hour to 7.
module epoch_to_local_time_us_dst (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  logic [31:0]         i_epoch_seconds,
    input  logic signed [4:0]   i_std_offset_hours,
    input  logic                i_follows_dst,
    output logic                empty,
    input  logic                pop,
    output logic                o_dst_active,
    output logic signed [4:0]   o_applied_offset,
    output logic [4:0]          o_local_hours,
    output logic [5:0]          o_local_minutes,
    output logic [5:0]          o_local_seconds,
    output logic [3:0]          o_hour_twelve,
    output logic                o_is_pm,
    input  logic                i_cfg_we,
    input  logic                i_cfg_index,
    input  logic [4:0]          i_cfg_data
);
    localparam logic CFG_START = 1'b0;
    localparam logic CFG_END   = 1'b1;

    logic [4:0]         r_on_hour, r_off_hour;
    logic               w_q_full, w_q_push, w_q_pop, w_q_empty;
    eltd_pkg::t_mid     w_q_in, w_q_out;
    eltd_pkg::t_res     w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_on_hour  <= 5'd8;
            r_off_hour <= 5'd7;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_START: r_on_hour  <= i_cfg_data;
                CFG_END:   r_off_hour <= i_cfg_data;
                default:   r_on_hour  <= r_on_hour;
            endcase
        end
    end

    eltd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .o_full     (full),
        .i_epoch    (i_epoch_seconds),
        .i_std_off  (i_std_offset_hours),
        .i_follows  (i_follows_dst),
        .i_on_hour  (r_on_hour),
        .i_off_hour (r_off_hour),
        .i_q_full   (w_q_full),
        .o_q_push   (w_q_push),
        .o_q_data   (w_q_in)
    );

    eltd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_data  (w_q_in),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_data  (w_q_out),
        .o_empty (w_q_empty)
    );

    eltd_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_data  (w_q_out),
        .i_q_empty (w_q_empty),
        .o_q_pop   (w_q_pop),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_res     (w_res)
    );

    assign o_dst_active     = w_res.dst_active;
    assign o_applied_offset = w_res.applied_offset;
    assign o_local_hours    = w_res.local_hours;
    assign o_local_minutes  = w_res.local_minutes;
    assign o_local_seconds  = w_res.local_seconds;
    assign o_hour_twelve    = w_res.hour_twelve;
    assign o_is_pm          = w_res.is_pm;

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for epoch_to_local_time_us_dst: US DST window, offset and time of day.
// Depends on eltd_pkg for the result type; drives the queue-style ports and checks each result.
module testbench;

    localparam logic REG_DST_START = 1'b0;
    localparam logic REG_DST_END   = 1'b1;
    localparam int   WATCHDOG_MAX  = 3000;
    localparam int   HOLD_CYCLES   = 80;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              push = 1'b0;
    logic              full;
    logic [31:0]       i_epoch_seconds = '0;
    logic signed [4:0] i_std_offset_hours = '0;
    logic              i_follows_dst = 1'b0;
    logic              empty;
    logic              pop = 1'b0;
    logic              o_dst_active;
    logic signed [4:0] o_applied_offset;
    logic [4:0]        o_local_hours;
    logic [5:0]        o_local_minutes;
    logic [5:0]        o_local_seconds;
    logic [3:0]        o_hour_twelve;
    logic              o_is_pm;
    logic              i_cfg_we = 1'b0;
    logic              i_cfg_index = 1'b0;
    logic [4:0]        i_cfg_data = '0;

    eltd_pkg::t_res local_time_q[$];
    logic [4:0] start_hour = 5'd8;
    logic [4:0] end_hour   = 5'd7;
    int         mismatches = 0;
    int         stall_cycles = 0;
    int         hold_cycles = 0;
    bit         hold_req = 1'b0;
    bit         steady = 1'b0;
    int         quiet_cycles = 0;

    epoch_to_local_time_us_dst dut (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Day number of the first day of month mon (3..12) in year yr.
    function automatic longint month_start_day(longint yr, longint mon);
        longint era, yoe, doy, doe;
        era = yr / 400;
        yoe = yr - era * 400;
        doy = (153 * (mon - 3) + 2) / 5;
        doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
        return era * 146097 + doe - 719468;
    endfunction

    function automatic longint sunday_on_or_after(longint day);
        longint wd;
        wd = (day + 4) % 7;
        return (wd == 0) ? day : day + 7 - wd;
    endfunction

    // Epoch second where the window opens (march) or closes.
    function automatic longint dst_edge_sec(longint yr, bit march, logic [4:0] hr);
        longint day;
        day = march ? sunday_on_or_after(month_start_day(yr, 3)) + 7
                    : sunday_on_or_after(month_start_day(yr, 11));
        return day * 86400 + longint'(hr) * 3600;
    endfunction

    function automatic longint utc_year(logic [31:0] epoch);
        longint z, era, doe, yoe, doy, mp;
        z   = longint'(epoch / 86400) + 719468;
        era = z / 146097;
        doe = z - era * 146097;
        yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
        doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
        mp  = (5 * doy + 2) / 153;
        return yoe + era * 400 + ((mp >= 10) ? 1 : 0);
    endfunction

    function automatic eltd_pkg::t_res predict_local_time(logic [31:0] epoch,
                                                          logic signed [4:0] off,
                                                          logic follows);
        eltd_pkg::t_res r;
        longint yr, ep, applied, sod;
        yr = utc_year(epoch);
        ep = longint'(epoch);
        r.dst_active = (ep >= dst_edge_sec(yr, 1'b1, start_hour)) &&
                       (ep < dst_edge_sec(yr, 1'b0, end_hour));
        applied = longint'(off) + ((follows && r.dst_active) ? 1 : 0);
        if (applied > 15) applied = 15;
        sod = ep % 86400 + applied * 3600;
        if (sod < 0) sod += 86400;
        else if (sod >= 86400) sod -= 86400;
        r.applied_offset = 5'(applied);
        r.local_hours    = 5'(sod / 3600);
        r.local_minutes  = 6'((sod / 60) % 60);
        r.local_seconds  = 6'(sod % 60);
        r.hour_twelve    = ((sod / 3600) % 12 == 0) ? 4'd12 : 4'((sod / 3600) % 12);
        r.is_pm          = (sod / 3600) >= 12;
        return r;
    endfunction

    task automatic report_mismatch(string field, int got, int want);
        $display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $realtime);
        mismatches++;
    endtask

    // Offer one item and hold it until the transfer; push stays high afterwards.
    task automatic send_conversion(logic [31:0] epoch, logic signed [4:0] off, logic follows);
        push               <= 1'b1;
        i_epoch_seconds    <= epoch;
        i_std_offset_hours <= off;
        i_follows_dst      <= follows;
        do @(posedge i_clk); while (full);
        local_time_q.push_back(predict_local_time(epoch, off, follows));
    endtask

    task automatic sender_gap();
        int n;
        if (!steady && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 3);
            push <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        @(posedge i_clk);
        while (local_time_q.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
    endtask

    task automatic write_register(logic idx, logic [4:0] value);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        if (idx == REG_DST_START) start_hour = value;
        else end_hour = value;
    endtask

    // Epoch near a window edge of a random year, or anywhere in the range.
    task automatic send_random();
        longint ep;
        bit     march;
        if ($urandom_range(0, 1) == 0) begin
            march = 1'($urandom_range(0, 1));
            ep = dst_edge_sec($urandom_range(1970, 2105), march,
                              march ? start_hour : end_hour);
            ep = ep + $urandom_range(0, 14400) - 7200;
            if (ep < 0 || ep > 64'hFFFF_FFFF) ep = $urandom;
        end else begin
            ep = $urandom;
        end
        send_conversion(32'(ep), 5'($urandom_range(0, 31)), 1'($urandom_range(0, 1)));
        sender_gap();
    endtask

    task automatic test_directed();
        longint on, off;
        on  = dst_edge_sec(2024, 1'b1, start_hour);
        off = dst_edge_sec(2024, 1'b0, end_hour);
        send_conversion(32'd0, 5'sd0, 1'b1);
        send_conversion(32'hFFFF_FFFF, -5'sd16, 1'b1);
        send_conversion(32'(on - 1), -5'sd5, 1'b1);
        send_conversion(32'(on), -5'sd5, 1'b1);
        send_conversion(32'(on), -5'sd5, 1'b0);
        send_conversion(32'(off - 1), -5'sd8, 1'b1);
        send_conversion(32'(off), -5'sd8, 1'b1);
        // saturation of the applied offset under DST
        send_conversion(32'(on + 3600), 5'sd15, 1'b1);
        send_conversion(32'(on + 3600), 5'sd14, 1'b1);
        send_conversion(32'(on + 3600), -5'sd16, 1'b1);
        // wrap backward and forward across midnight
        send_conversion(32'd86399, 5'sd15, 1'b0);
        send_conversion(32'd86400, -5'sd12, 1'b0);
        send_conversion(32'd43200, 5'sd0, 1'b0);
        send_conversion(32'd46799, 5'sd0, 1'b0);
        send_conversion(32'(dst_edge_sec(2105, 1'b0, end_hour)), 5'sd3, 1'b1);
        send_conversion(32'(dst_edge_sec(1970, 1'b1, start_hour)), 5'sd1, 1'b1);
        send_conversion(32'h5555_5555, 5'sd10, 1'b1);
        send_conversion(32'hAAAA_AAAA, -5'sd6, 1'b1);
    endtask

    task automatic test_register_settings();
        logic [4:0] hours [5] = '{5'd0, 5'd23, 5'd31, 5'd12, 5'd8};
        logic [4:0] ends  [5] = '{5'd0, 5'd23, 5'd31, 5'd2, 5'd7};
        for (int k = 0; k < 5; k++) begin
            write_register(REG_DST_START, hours[k]);
            write_register(REG_DST_END, ends[k]);
            repeat (110) send_random();
        end
        write_register(REG_DST_START, 5'($urandom_range(0, 31)));
        write_register(REG_DST_END, 5'($urandom_range(0, 31)));
        repeat (100) send_random();
    endtask

    task automatic test_backpressure();
        push <= 1'b0;
        @(posedge i_clk);
        hold_req = 1'b1;
        for (int k = 0; k < 30; k++) send_conversion($urandom, 5'($urandom_range(0, 31)),
                                                      1'($urandom_range(0, 1)));
    endtask

    task automatic test_full_rate();
        steady = 1'b1;
        repeat (60) send_random();
    endtask

    always @(posedge i_clk) begin
        eltd_pkg::t_res want;
        if (pop && !empty) begin
            if (local_time_q.size() == 0) begin
                $display("unexpected result at %0t", $realtime);
                mismatches++;
            end else begin
                want = local_time_q.pop_front();
                if (o_dst_active != want.dst_active)
                    report_mismatch("dst_active", o_dst_active, want.dst_active);
                if (o_applied_offset != want.applied_offset)
                    report_mismatch("applied_offset", o_applied_offset, want.applied_offset);
                if (o_local_hours != want.local_hours)
                    report_mismatch("local_hours", o_local_hours, want.local_hours);
                if (o_local_minutes != want.local_minutes)
                    report_mismatch("local_minutes", o_local_minutes, want.local_minutes);
                if (o_local_seconds != want.local_seconds)
                    report_mismatch("local_seconds", o_local_seconds, want.local_seconds);
                if (o_hour_twelve != want.hour_twelve)
                    report_mismatch("hour_twelve", o_hour_twelve, want.hour_twelve);
                if (o_is_pm != want.is_pm)
                    report_mismatch("is_pm", o_is_pm, want.is_pm);
            end
        end
        if (hold_req) begin
            hold_req = 1'b0;
            hold_cycles = HOLD_CYCLES;
        end
        if (hold_cycles > 0) begin
            hold_cycles--;
            pop <= 1'b0;
        end else if (stall_cycles > 0) begin
            stall_cycles--;
            pop <= 1'b0;
        end else if (!steady && $urandom_range(0, 6) == 0) begin
            // start a stall burst here; stall_cycles holds its remaining length
            stall_cycles = $urandom_range(0, 2);
            pop <= 1'b0;
        end else begin
            pop <= 1'b1;
        end
    end

    // Abort when no transfer happens on either side for too long.
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_MAX) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_register_settings();
        test_backpressure();
        test_full_rate();
        wait_drained();
        if (mismatches == 0 && local_time_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
